[hdl/bre_pkg.sv]
// shared types and constants of the byte rate meter
`default_nettype none

package bre_pkg;

   // field widths
   localparam int COUNT_W = 32;
   localparam int TIME_W  = 63;
   localparam int RATE_W  = 32;
   localparam int UNIT_W  = 2;
   localparam int WHOLE_W = 12;
   localparam int TENTH_W = 4;

   // rate arithmetic
   localparam int US_W       = 20;
   localparam logic [US_W-1:0] US_PER_S = 20'd1000000;
   localparam int DIVIDEND_W = COUNT_W + US_W;
   localparam int DIVISOR_W  = TIME_W;

   // unit split
   localparam int KIB_SHIFT  = 10;
   localparam int MIB_SHIFT  = 20;
   localparam int DIGIT_W    = 16;
   localparam int RECIP_W    = 17;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;
   localparam int RECIP_SHIFT = 19;

   localparam logic [UNIT_W-1:0] UNIT_B = 2'd0;
   localparam logic [UNIT_W-1:0] UNIT_K = 2'd1;
   localparam logic [UNIT_W-1:0] UNIT_M = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_SMOOTH,
      ST_SPLIT,
      ST_DONE
   } seq_state_type;

endpackage

`default_nettype wire

[hdl/bre_ifs.sv]
// sample and result channel interfaces of the byte rate meter
`default_nettype none

interface bre_req_if;
   logic                        valid;
   logic                        ready;
   logic [bre_pkg::COUNT_W-1:0] down_count;
   logic [bre_pkg::COUNT_W-1:0] up_count;
   logic [bre_pkg::TIME_W-1:0]  now_us;
   logic                        bridge_on;

   modport source (output valid, down_count, up_count, now_us, bridge_on, input ready);
   modport sink   (input valid, down_count, up_count, now_us, bridge_on, output ready);
endinterface

interface bre_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        active;
   logic [bre_pkg::RATE_W-1:0]  down_smoothed;
   logic [bre_pkg::RATE_W-1:0]  up_smoothed;
   logic [bre_pkg::UNIT_W-1:0]  down_unit;
   logic [bre_pkg::WHOLE_W-1:0] down_whole;
   logic [bre_pkg::TENTH_W-1:0] down_tenth;
   logic [bre_pkg::UNIT_W-1:0]  up_unit;
   logic [bre_pkg::WHOLE_W-1:0] up_whole;
   logic [bre_pkg::TENTH_W-1:0] up_tenth;

   modport source (output valid, active, down_smoothed, up_smoothed, down_unit, down_whole,
                   down_tenth, up_unit, up_whole, up_tenth, input ready);
   modport sink   (input valid, active, down_smoothed, up_smoothed, down_unit, down_whole,
                   down_tenth, up_unit, up_whole, up_tenth, output ready);
endinterface

`default_nettype wire

[hdl/bre_div.sv]
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module bre_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bre_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [bre_pkg::DIVISOR_W-1:0]  divisor,
   output logic                          done,
   output logic [bre_pkg::DIVIDEND_W-1:0] quotient
);

   localparam int NW  = bre_pkg::DIVIDEND_W;
   localparam int DW  = bre_pkg::DIVISOR_W;
   localparam int CW  = $clog2(NW + 1);
   localparam logic [CW-1:0] LAST = CW'(NW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quot_ff, quot_in;

   logic [DW:0]   rem_sh;
   logic [DW+1:0] diff;
   logic          fits;

   // shift in the next dividend bit and try the subtract
   always_comb begin
      rem_sh = {rem_ff, quot_ff[NW-1]};
      diff   = {1'b0, rem_sh} - {2'b00, divisor};
      fits   = !diff[DW+1];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quot_in  = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
         quot_in  = {quot_ff[NW-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

[hdl/bre_split.sv]
// splits a rate into unit, whole part and tenths via a register
`default_nettype none

module bre_split (
   input  logic                        clock,
   input  logic                        load,
   input  logic [bre_pkg::RATE_W-1:0]  rate,
   output logic [bre_pkg::UNIT_W-1:0]  unit,
   output logic [bre_pkg::WHOLE_W-1:0] whole,
   output logic [bre_pkg::TENTH_W-1:0] tenth
);

   localparam int RW  = bre_pkg::RATE_W;
   localparam int TW  = bre_pkg::DIGIT_W;
   localparam int PW  = TW + bre_pkg::RECIP_W;
   localparam int WW  = bre_pkg::WHOLE_W;
   localparam int KS  = bre_pkg::KIB_SHIFT;
   localparam int MS  = bre_pkg::MIB_SHIFT;
   localparam int RS  = bre_pkg::RECIP_SHIFT;

   logic [bre_pkg::UNIT_W-1:0] unit_ff, unit_in;
   logic [TW-1:0]              t_ff, t_in;

   logic [RW+3:0] rate_x10;
   logic [PW-1:0] prod;
   logic [WW-1:0] quo;
   logic [TW-1:0] quo_x10;
   logic [TW-1:0] rem;

   // first step: unit and value (rate or rate * 10 >> shift)
   always_comb begin
      rate_x10 = {rate, 3'b000} + {2'b00, rate, 1'b0};
      if (rate[RW-1:KS] == '0) begin
         unit_in = bre_pkg::UNIT_B;
         t_in    = TW'(rate);
      end else if (rate[RW-1:MS] == '0) begin
         unit_in = bre_pkg::UNIT_K;
         t_in    = rate_x10[KS+TW-1:KS];
      end else begin
         unit_in = bre_pkg::UNIT_M;
         t_in    = rate_x10[MS+TW-1:MS];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         unit_ff <= unit_in;
         t_ff    <= t_in;
      end
   end

   // second step: divide by ten through the reciprocal
   always_comb begin
      prod    = PW'(t_ff) * PW'(bre_pkg::RECIP_TEN);
      quo     = prod[RS+WW-1:RS];
      quo_x10 = {quo, 3'b000} + {quo, 1'b0};
      rem     = t_ff - quo_x10;
   end

   always_comb begin
      unit = unit_ff;
      if (unit_ff == bre_pkg::UNIT_B) begin
         whole = t_ff[WW-1:0];
         tenth = '0;
      end else begin
         whole = quo;
         tenth = rem[bre_pkg::TENTH_W-1:0];
      end
   end

endmodule

`default_nettype wire

[hdl/byte_rate_ewma_meter_top.sv]
// top level of the smoothed byte rate meter
//
// usage
//   req_bus carries one sample per beat: the two wrapping byte counters, a
//   microsecond timestamp and the bridge_on flag. rsp_bus returns exactly one
//   result beat per sample, in order
//   with bridge_on high the block works out both raw rates (delta * 1e6 /
//   elapsed us, saturated to 32 bits, zero when time did not advance),
//   folds each into a 7/8 old + 1/8 new average and splits it into unit,
//   whole part and tenths. with bridge_on low the state is kept and an all
//   zero result with active low comes back
//   one sample at a time: req_bus.ready is high only while the sequencer idles
//   for an enabled sample the sequencer runs mul, start, div, smooth and split
//   once per channel, download first, on the shared 52-step divider; the divide
//   is skipped when time did not advance, and bridge_on low goes straight to done
//   the result sits in an output register, so a stalled receiver holds only
//   that beat; the next sample is accepted and worked on meanwhile, and its
//   result waits until the output register frees up
//   synchronous reset clears the sequencer, the stored counters, timestamp
//   and both averages, and drops rsp_bus.valid
`default_nettype none

module byte_rate_ewma_meter_top (
   input  logic      clock,
   input  logic      reset,
   bre_req_if.sink   req_bus,
   bre_rsp_if.source rsp_bus
);

   localparam int CW = bre_pkg::COUNT_W;
   localparam int TW = bre_pkg::TIME_W;
   localparam int RW = bre_pkg::RATE_W;
   localparam int NW = bre_pkg::DIVIDEND_W;

   bre_pkg::seq_state_type state_ff, state_in;

   // sequencer strobes
   logic req_ready;
   logic mul_en;
   logic div_start;
   logic smooth_en;
   logic split_cap;
   logic rsp_load;
   logic accept;

   // architectural state
   logic [CW-1:0] last_down_ff, last_down_in;
   logic [CW-1:0] last_up_ff, last_up_in;
   logic [TW-1:0] last_time_ff, last_time_in;
   logic [RW-1:0] avg_ff [0:1];
   logic [RW-1:0] avg_in;

   // per sample working registers
   logic          chan_ff, chan_in;
   logic          on_ff;
   logic          stall_ff;
   logic [CW-1:0] delta_ff [0:1];
   logic [TW-1:0] elapsed_ff, elapsed_in;
   logic [NW-1:0] dividend_ff, dividend_in;

   // assembled result, one slot per channel
   logic [RW-1:0]              res_smoothed_ff [0:1];
   logic [bre_pkg::UNIT_W-1:0] res_unit_ff [0:1];
   logic [bre_pkg::WHOLE_W-1:0] res_whole_ff [0:1];
   logic [bre_pkg::TENTH_W-1:0] res_tenth_ff [0:1];

   // output register
   logic rsp_valid_ff, rsp_valid_in;

   // divider and split unit
   logic                        div_done;
   logic [NW-1:0]               quotient;
   logic [RW-1:0]               sample;
   logic [RW+2:0]               avg_sum;
   logic [bre_pkg::UNIT_W-1:0]  split_unit;
   logic [bre_pkg::WHOLE_W-1:0] split_whole;
   logic [bre_pkg::TENTH_W-1:0] split_tenth;

   //--------------------------------------------------------------------------
   // sequencer
   //--------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bre_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = req_bus.bridge_on ? bre_pkg::ST_MUL : bre_pkg::ST_DONE;
            end
         end
         bre_pkg::ST_MUL: begin
            // no elapsed time means a zero rate, skip the divide
            state_in = stall_ff ? bre_pkg::ST_SMOOTH : bre_pkg::ST_START;
         end
         bre_pkg::ST_START: begin
            state_in = bre_pkg::ST_DIV;
         end
         bre_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = bre_pkg::ST_SMOOTH;
            end
         end
         bre_pkg::ST_SMOOTH: begin
            state_in = bre_pkg::ST_SPLIT;
         end
         bre_pkg::ST_SPLIT: begin
            state_in = chan_ff ? bre_pkg::ST_DONE : bre_pkg::ST_MUL;
         end
         bre_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = bre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bre_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mul_en    = 1'b0;
      div_start = 1'b0;
      smooth_en = 1'b0;
      split_cap = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         bre_pkg::ST_IDLE:   req_ready = 1'b1;
         bre_pkg::ST_MUL:    mul_en    = 1'b1;
         bre_pkg::ST_START:  div_start = 1'b1;
         bre_pkg::ST_DIV:    ;
         bre_pkg::ST_SMOOTH: smooth_en = 1'b1;
         bre_pkg::ST_SPLIT:  split_cap = 1'b1;
         bre_pkg::ST_DONE:   rsp_load  = !rsp_valid_ff || rsp_bus.ready;
         default:            ;
      endcase
   end

   assign accept = req_ready && req_bus.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bre_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   //--------------------------------------------------------------------------
   // sample intake: deltas, elapsed time, stored counters
   //--------------------------------------------------------------------------
   always_comb begin
      last_down_in = last_down_ff;
      last_up_in   = last_up_ff;
      last_time_in = last_time_ff;
      if (accept && req_bus.bridge_on) begin
         last_down_in = req_bus.down_count;
         last_up_in   = req_bus.up_count;
         last_time_in = req_bus.now_us;
      end
   end

   // time that did not move forward counts as no elapsed time
   assign elapsed_in = (req_bus.now_us > last_time_ff) ? (req_bus.now_us - last_time_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_down_ff <= '0;
         last_up_ff   <= '0;
         last_time_ff <= '0;
      end else begin
         last_down_ff <= last_down_in;
         last_up_ff   <= last_up_in;
         last_time_ff <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         on_ff       <= req_bus.bridge_on;
         delta_ff[0] <= req_bus.down_count - last_down_ff;
         delta_ff[1] <= req_bus.up_count - last_up_ff;
         elapsed_ff  <= elapsed_in;
         stall_ff    <= (elapsed_in == '0);
      end
   end

   // channel pointer: download first, then upload
   always_comb begin
      chan_in = chan_ff;
      if (accept) begin
         chan_in = 1'b0;
      end else if (split_cap) begin
         chan_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= 1'b0;
      end else begin
         chan_ff <= chan_in;
      end
   end

   //--------------------------------------------------------------------------
   // raw rate: delta * 1e6, then the shared divider
   //--------------------------------------------------------------------------
   assign dividend_in = NW'(delta_ff[chan_ff]) * NW'(bre_pkg::US_PER_S);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         dividend_ff <= dividend_in;
      end
   end

   bre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // saturate to 32 bits, zero rate when time stood still
   always_comb begin
      if (stall_ff) begin
         sample = '0;
      end else if (quotient[NW-1:RW] != '0) begin
         sample = '1;
      end else begin
         sample = quotient[RW-1:0];
      end
   end

   //--------------------------------------------------------------------------
   // smoothing: (7 * old + new) / 8
   //--------------------------------------------------------------------------
   always_comb begin
      avg_sum = {avg_ff[chan_ff], 3'b000} - {3'b000, avg_ff[chan_ff]} + {3'b000, sample};
      avg_in  = avg_sum[RW+2:3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff[0] <= '0;
         avg_ff[1] <= '0;
      end else if (smooth_en) begin
         avg_ff[chan_ff] <= avg_in;
      end
   end

   bre_split u_split (
      .clock (clock),
      .load  (smooth_en),
      .rate  (avg_in),
      .unit  (split_unit),
      .whole (split_whole),
      .tenth (split_tenth)
   );

   always_ff @(posedge clock) begin
      if (smooth_en) begin
         res_smoothed_ff[chan_ff] <= avg_in;
      end
      if (split_cap) begin
         res_unit_ff[chan_ff]  <= split_unit;
         res_whole_ff[chan_ff] <= split_whole;
         res_tenth_ff[chan_ff] <= split_tenth;
      end
   end

   //--------------------------------------------------------------------------
   // output register; an idle sample reports all zeros
   //--------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bus.active        <= on_ff;
         rsp_bus.down_smoothed <= on_ff ? res_smoothed_ff[0] : '0;
         rsp_bus.up_smoothed   <= on_ff ? res_smoothed_ff[1] : '0;
         rsp_bus.down_unit     <= on_ff ? res_unit_ff[0] : bre_pkg::UNIT_B;
         rsp_bus.down_whole    <= on_ff ? res_whole_ff[0] : '0;
         rsp_bus.down_tenth    <= on_ff ? res_tenth_ff[0] : '0;
         rsp_bus.up_unit       <= on_ff ? res_unit_ff[1] : bre_pkg::UNIT_B;
         rsp_bus.up_whole      <= on_ff ? res_whole_ff[1] : '0;
         rsp_bus.up_tenth      <= on_ff ? res_tenth_ff[1] : '0;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign req_bus.ready = req_ready;

endmodule

`default_nettype wire

[hdl/bre_checker.sv]
// port level checks of the byte rate meter, bound to the top level
`default_nettype none

module bre_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_active,
   input logic [bre_pkg::RATE_W-1:0]  rsp_down_smoothed,
   input logic [bre_pkg::RATE_W-1:0]  rsp_up_smoothed,
   input logic [bre_pkg::UNIT_W-1:0]  rsp_down_unit,
   input logic [bre_pkg::WHOLE_W-1:0] rsp_down_whole,
   input logic [bre_pkg::TENTH_W-1:0] rsp_down_tenth,
   input logic [bre_pkg::UNIT_W-1:0]  rsp_up_unit,
   input logic [bre_pkg::WHOLE_W-1:0] rsp_up_whole,
   input logic [bre_pkg::TENTH_W-1:0] rsp_up_tenth
);

   localparam int RW = bre_pkg::RATE_W;
   localparam int KS = bre_pkg::KIB_SHIFT;
   localparam int MS = bre_pkg::MIB_SHIFT;

   // a stalled result beat stays valid with active and smoothed rates unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_active)
         && $stable(rsp_down_smoothed) && $stable(rsp_up_smoothed))
      else $error("result beat changed while stalled");

   // one sample at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while busy");

   // idle results carry nothing
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_down_smoothed == '0 && rsp_up_smoothed == '0
         && rsp_down_whole == '0 && rsp_down_tenth == '0
         && rsp_up_whole == '0 && rsp_up_tenth == '0)
      else $error("idle result with non-zero fields");

   // unit follows the smoothed rate, byte unit shows the rate itself
   a_unit_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_down_unit == bre_pkg::UNIT_B) == (rsp_down_smoothed[RW-1:KS] == '0))
         && ((rsp_down_unit == bre_pkg::UNIT_M) == (rsp_down_smoothed[RW-1:MS] != '0))
         && ((rsp_up_unit == bre_pkg::UNIT_B) == (rsp_up_smoothed[RW-1:KS] == '0))
         && ((rsp_up_unit == bre_pkg::UNIT_M) == (rsp_up_smoothed[RW-1:MS] != '0))
         && (rsp_down_unit != bre_pkg::UNIT_B
             || (rsp_down_tenth == '0 && rsp_down_whole == rsp_down_smoothed[11:0]))
         && (rsp_up_unit != bre_pkg::UNIT_B
             || (rsp_up_tenth == '0 && rsp_up_whole == rsp_up_smoothed[11:0])))
      else $error("unit split does not match smoothed rate");

endmodule

bind byte_rate_ewma_meter_top bre_checker u_bre_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_active        (rsp_bus.active),
   .rsp_down_smoothed (rsp_bus.down_smoothed),
   .rsp_up_smoothed   (rsp_bus.up_smoothed),
   .rsp_down_unit     (rsp_bus.down_unit),
   .rsp_down_whole    (rsp_bus.down_whole),
   .rsp_down_tenth    (rsp_bus.down_tenth),
   .rsp_up_unit       (rsp_bus.up_unit),
   .rsp_up_whole      (rsp_bus.up_whole),
   .rsp_up_tenth      (rsp_bus.up_tenth)
);

`default_nettype wire

[sim/tb_byte_rate_ewma_meter_top.sv]
// self-checking testbench for the smoothed byte rate meter
`timescale 1ns / 1ps

module tb_byte_rate_ewma_meter_top;

   // run shape
   localparam int RANDOM_ITEMS    = 780;
   localparam int CALM_ITEMS      = 80;
   localparam int LONG_HOLD       = 1500;
   localparam int LONG_HOLD_AFTER = 200;
   localparam int TAIL_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int REPORT_LIMIT    = 10;

   // one sample beat plus the pacing hints that travel with it
   typedef struct packed {
      logic [bre_pkg::COUNT_W-1:0] down_count;
      logic [bre_pkg::COUNT_W-1:0] up_count;
      logic [bre_pkg::TIME_W-1:0]  now_us;
      logic                        bridge_on;
      logic                        drain_first;
      logic                        calm;
      logic [6:0]                  idle_pct;
   } sample_type;

   // one result beat
   typedef struct packed {
      logic                        active;
      logic [bre_pkg::RATE_W-1:0]  down_smoothed;
      logic [bre_pkg::RATE_W-1:0]  up_smoothed;
      logic [bre_pkg::UNIT_W-1:0]  down_unit;
      logic [bre_pkg::WHOLE_W-1:0] down_whole;
      logic [bre_pkg::TENTH_W-1:0] down_tenth;
      logic [bre_pkg::UNIT_W-1:0]  up_unit;
      logic [bre_pkg::WHOLE_W-1:0] up_whole;
      logic [bre_pkg::TENTH_W-1:0] up_tenth;
   } reading_type;

   // a rate broken into unit, whole part and tenths digit
   typedef struct packed {
      logic [bre_pkg::UNIT_W-1:0]  unit;
      logic [bre_pkg::WHOLE_W-1:0] whole;
      logic [bre_pkg::TENTH_W-1:0] tenth;
   } rate_split_type;

   logic clock = 1'b0;
   logic reset;

   bre_req_if req_bus ();
   bre_rsp_if rsp_bus ();

   byte_rate_ewma_meter_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // meter state as the predictor sees it, zero from the start like after reset
   // ---------------------------------------------------------------------
   logic [bre_pkg::COUNT_W-1:0] prev_down = '0;
   logic [bre_pkg::COUNT_W-1:0] prev_up   = '0;
   logic [63:0]                 prev_us   = '0;
   logic [bre_pkg::RATE_W-1:0]  down_mean = '0;
   logic [bre_pkg::RATE_W-1:0]  up_mean   = '0;

   sample_type  sample_queue[$];       // filled up front, drained by the driver
   reading_type awaited_readings[$];   // predicted results, oldest first

   sample_type  offered = '0;
   logic        offering = 1'b0;
   int          send_gap = 0;
   int          samples_taken = 0;
   int          idle_pct_now = 0;
   logic        calm_phase = 1'b0;

   int          hold_left = 0;
   logic        long_hold_done = 1'b0;
   logic        stall_now;

   reading_type seen_reading;
   int          readings_seen = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   // pacing applied to samples as they are queued
   int          gen_pct = 0;
   logic        gen_calm = 1'b0;

   // bytes per second from a counter delta and elapsed microseconds,
   // zero when no time passed, pinned at the top when it overflows 32 bits
   function automatic logic [bre_pkg::RATE_W-1:0] rate_of(
      input logic [bre_pkg::COUNT_W-1:0] delta,
      input logic [63:0]                 elapsed);
      logic [63:0] q;
      if (elapsed == 64'd0) return '0;
      q = ({32'd0, delta} * 64'd1000000) / elapsed;
      return (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   // 7/8 of the old mean plus 1/8 of the new rate, truncated
   function automatic logic [bre_pkg::RATE_W-1:0] smooth_rate(
      input logic [bre_pkg::RATE_W-1:0] mean,
      input logic [bre_pkg::RATE_W-1:0] rate);
      logic [63:0] acc;
      acc = {32'd0, mean} * 64'd7 + {32'd0, rate};
      return acc[34:3];
   endfunction

   function automatic rate_split_type split_rate(input logic [bre_pkg::RATE_W-1:0] bps);
      rate_split_type sp;
      logic [63:0]    tenths;
      logic [63:0]    whole_part;
      logic [63:0]    digit;
      sp = '0;
      if (bps < (32'd1 << bre_pkg::KIB_SHIFT)) begin
         sp.unit  = bre_pkg::UNIT_B;
         sp.whole = bps[bre_pkg::WHOLE_W-1:0];
         return sp;
      end
      if (bps < (32'd1 << bre_pkg::MIB_SHIFT)) begin
         sp.unit = bre_pkg::UNIT_K;
         tenths  = ({32'd0, bps} * 64'd10) >> bre_pkg::KIB_SHIFT;
      end else begin
         sp.unit = bre_pkg::UNIT_M;
         tenths  = ({32'd0, bps} * 64'd10) >> bre_pkg::MIB_SHIFT;
      end
      whole_part = tenths / 64'd10;
      digit      = tenths % 64'd10;
      sp.whole   = whole_part[bre_pkg::WHOLE_W-1:0];
      sp.tenth   = digit[bre_pkg::TENTH_W-1:0];
      return sp;
   endfunction

   // advances the predicted meter state by one accepted sample
   function automatic reading_type next_reading(input sample_type s);
      reading_type    r;
      logic [63:0]    stamp;
      logic [63:0]    elapsed;
      rate_split_type sp;
      r = '0;
      // bridge off: state untouched, all-zero idle result
      if (!s.bridge_on) return r;
      stamp   = {1'b0, s.now_us};
      elapsed = (stamp > prev_us) ? stamp - prev_us : 64'd0;
      down_mean = smooth_rate(down_mean, rate_of(s.down_count - prev_down, elapsed));
      up_mean   = smooth_rate(up_mean, rate_of(s.up_count - prev_up, elapsed));
      prev_down = s.down_count;
      prev_up   = s.up_count;
      prev_us   = stamp;
      r.active        = 1'b1;
      r.down_smoothed = down_mean;
      r.up_smoothed   = up_mean;
      sp = split_rate(down_mean);
      r.down_unit  = sp.unit;
      r.down_whole = sp.whole;
      r.down_tenth = sp.tenth;
      sp = split_rate(up_mean);
      r.up_unit    = sp.unit;
      r.up_whole   = sp.whole;
      r.up_tenth   = sp.tenth;
      return r;
   endfunction

   // counter step drawn from a spread of magnitudes
   function automatic logic [bre_pkg::COUNT_W-1:0] pick_delta();
      logic [bre_pkg::COUNT_W-1:0] d;
      case ($urandom_range(0, 4))
         0:       d = '0;
         1:       d = $urandom_range(0, 4000);
         2:       d = $urandom_range(0, 2000000);
         3:       d = $urandom_range(0, 400000000);
         default: d = $urandom;
      endcase
      return d;
   endfunction

   function automatic logic [bre_pkg::TIME_W-1:0] rand_time();
      logic [63:0] r64;
      r64 = {$urandom, $urandom};
      return r64[bre_pkg::TIME_W-1:0];
   endfunction

   task automatic add_sample(input logic [bre_pkg::COUNT_W-1:0] dn,
                             input logic [bre_pkg::COUNT_W-1:0] up,
                             input logic [bre_pkg::TIME_W-1:0]  t,
                             input logic on, input logic drain);
      sample_type s;
      s.down_count  = dn;
      s.up_count    = up;
      s.now_us      = t;
      s.bridge_on   = on;
      s.drain_first = drain;
      s.calm        = gen_calm;
      s.idle_pct    = gen_pct[6:0];
      sample_queue.push_back(s);
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                  what, readings_seen, want, got);
   endtask

   task automatic check_reading(input reading_type want, input reading_type got);
      if (got.active !== want.active)
         note_mismatch("active", 32'(want.active), 32'(got.active));
      if (got.down_smoothed !== want.down_smoothed)
         note_mismatch("down_smoothed", want.down_smoothed, got.down_smoothed);
      if (got.up_smoothed !== want.up_smoothed)
         note_mismatch("up_smoothed", want.up_smoothed, got.up_smoothed);
      if (got.down_unit !== want.down_unit)
         note_mismatch("down_unit", 32'(want.down_unit), 32'(got.down_unit));
      if (got.down_whole !== want.down_whole)
         note_mismatch("down_whole", 32'(want.down_whole), 32'(got.down_whole));
      if (got.down_tenth !== want.down_tenth)
         note_mismatch("down_tenth", 32'(want.down_tenth), 32'(got.down_tenth));
      if (got.up_unit !== want.up_unit)
         note_mismatch("up_unit", 32'(want.up_unit), 32'(got.up_unit));
      if (got.up_whole !== want.up_whole)
         note_mismatch("up_whole", 32'(want.up_whole), 32'(got.up_whole));
      if (got.up_tenth !== want.up_tenth)
         note_mismatch("up_tenth", 32'(want.up_tenth), 32'(got.up_tenth));
   endtask

   // ---------------------------------------------------------------------
   // stimulus: directed samples first, then random traffic; reset, then
   // wait for the queues to run dry and settle the verdict
   // ---------------------------------------------------------------------
   initial begin
      logic [bre_pkg::COUNT_W-1:0] dn;
      logic [bre_pkg::COUNT_W-1:0] up;
      logic [bre_pkg::TIME_W-1:0]  t;
      logic [bre_pkg::TIME_W-1:0]  step;
      int                          sat_left;
      int                          kind;

      // every input known from time zero
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.down_count = '0;
      req_bus.up_count   = '0;
      req_bus.now_us     = '0;
      req_bus.bridge_on  = 1'b0;
      rsp_bus.ready      = 1'b0;

      gen_pct = 20;
      // bridge off with every field at its top value
      add_sample('1, '1, '1, 1'b0, 1'b0);
      // first enabled sample at time zero: time has not advanced past reset
      dn = '0; up = '0; t = '0;
      add_sample(dn, up, t, 1'b1, 1'b0);
      // plain byte rates, then kilobyte and megabyte rates
      dn = 32'd500; up = 32'd100; t = 63'd1000000;
      add_sample(dn, up, t, 1'b1, 1'b0);
      dn += 32'd20000; up += 32'd2000000; t = 63'd2000000;
      add_sample(dn, up, t, 1'b1, 1'b0);
      // same timestamp again: raw rates drop to zero, counters still stored
      dn += 32'd1000; up += 32'd1000;
      add_sample(dn, up, t, 1'b1, 1'b0);
      // clock steps backwards
      dn += 32'd1000; t = 63'd1500000;
      add_sample(dn, up, t, 1'b1, 1'b0);
      // nearly a full counter lap in one microsecond: rate saturates
      repeat (8) begin
         dn += 32'hFFFF_FFFF; up += 32'h8000_0000; t += 63'd1;
         add_sample(dn, up, t, 1'b1, 1'b0);
      end
      // counters wrap through zero
      dn = 32'hFFFF_FF00; up = 32'hFFFF_FFF0; t += 63'd200000;
      add_sample(dn, up, t, 1'b1, 1'b0);
      dn = 32'h0000_0100; up = 32'h0000_0010; t += 63'd200000;
      add_sample(dn, up, t, 1'b1, 1'b0);
      // enormous gap: rate rounds down to nothing
      dn += 32'd12345; t += 63'h4000_0000_0000_0000;
      add_sample(dn, up, t, 1'b1, 1'b0);
      // timestamp at its top
      dn += 32'd1; t = '1;
      add_sample(dn, up, t, 1'b1, 1'b0);
      // bridge off with every field zero
      add_sample('0, '0, '0, 1'b0, 1'b0);
      // back to time zero, then an ordinary poll
      t = '0;
      add_sample(dn, up, t, 1'b1, 1'b0);
      dn += 32'd300000; up += 32'd3000; t = 63'd200000;
      add_sample(dn, up, t, 1'b1, 1'b0);

      // random part: mostly well-formed polls with random deltas and spacing,
      // sprinkled with idle samples, stale stamps, noise and saturating runs
      sat_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 3))
               0:       gen_pct = 0;
               1:       gen_pct = 8;
               2:       gen_pct = 25;
               default: gen_pct = 60;
            endcase
         end
         gen_calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         if (gen_calm) gen_pct = 0;
         // one long run of saturation drives both means up toward their ceiling
         if (n == 150) sat_left = 70;
         kind = $urandom_range(0, 99);
         if (sat_left > 0) begin
            sat_left--;
            dn += 32'hFFFF_FFFF - $urandom_range(0, 1000);
            up += 32'hC000_0000 + $urandom_range(0, 1000);
            t  += 63'($urandom_range(1, 4));
            add_sample(dn, up, t, 1'b1, n == 0 || n == 400);
         end else if (kind < 60) begin
            case ($urandom_range(0, 3))
               0:       step = 63'($urandom_range(1, 1000));
               1:       step = 63'($urandom_range(195000, 205000));
               2:       step = 63'($urandom_range(1, 50000000));
               default: step = rand_time() >> $urandom_range(0, 62);
            endcase
            dn += pick_delta(); up += pick_delta(); t += step;
            add_sample(dn, up, t, 1'b1, n == 0 || n == 400);
         end else if (kind < 70) begin
            // idle sample: its contents must be ignored
            add_sample($urandom, $urandom, rand_time(), 1'b0, n == 0 || n == 400);
         end else if (kind < 78) begin
            // stale or repeated timestamp
            if (t > 63'd1000) t -= 63'($urandom_range(0, 1000));
            dn += pick_delta(); up += pick_delta();
            add_sample(dn, up, t, 1'b1, n == 0 || n == 400);
         end else if (kind < 86) begin
            // noise: everything random
            dn = $urandom; up = $urandom; t = rand_time();
            add_sample(dn, up, t, 1'b1, n == 0 || n == 400);
         end else begin
            sat_left = $urandom_range(2, 20);
            dn += pick_delta(); up += pick_delta(); t += 63'($urandom_range(0, 300000));
            add_sample(dn, up, t, 1'b1, n == 0 || n == 400);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (sample_queue.size() != 0 || offering || awaited_readings.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_readings.size() == 0)
         $display("[byte_rate_ewma_meter_top] OK");
      else
         $display("[byte_rate_ewma_meter_top] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // driver: offers queued samples, idles in random bursts, and predicts the
   // result of every beat it sees accepted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         send_gap = 0;
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_readings.push_back(next_reading(offered));
            samples_taken++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (sample_queue.size() != 0) begin
               // a marked sample waits until every result is back
               if (!(sample_queue[0].drain_first && awaited_readings.size() != 0)) begin
                  if ($urandom_range(1, 100) <= sample_queue[0].idle_pct) begin
                     send_gap = $urandom_range(0, 12);
                  end else begin
                     offered      = sample_queue.pop_front();
                     offering     = 1'b1;
                     idle_pct_now = int'(offered.idle_pct);
                     calm_phase   = offered.calm;
                  end
               end
            end
         end
         // valid stays up across back-to-back beats: single assignment per edge
         req_bus.valid      <= offering;
         req_bus.down_count <= offered.down_count;
         req_bus.up_count   <= offered.up_count;
         req_bus.now_us     <= offered.now_us;
         req_bus.bridge_on  <= offered.bridge_on;
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall bursts, plus one long hold-off once traffic is
   // flowing so that the output register fills and the input backs up
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_now = 1'b1;
         if (hold_left > 0) begin
            hold_left--;
         end else if (!long_hold_done && samples_taken >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
         end else if (!calm_phase && $urandom_range(1, 100) <= idle_pct_now) begin
            hold_left = $urandom_range(0, 12);
         end else begin
            stall_now = 1'b0;
         end
         rsp_bus.ready <= !stall_now;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every accepted result beat against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_reading.active        = rsp_bus.active;
         seen_reading.down_smoothed = rsp_bus.down_smoothed;
         seen_reading.up_smoothed   = rsp_bus.up_smoothed;
         seen_reading.down_unit     = rsp_bus.down_unit;
         seen_reading.down_whole    = rsp_bus.down_whole;
         seen_reading.down_tenth    = rsp_bus.down_tenth;
         seen_reading.up_unit       = rsp_bus.up_unit;
         seen_reading.up_whole      = rsp_bus.up_whole;
         seen_reading.up_tenth      = rsp_bus.up_tenth;
         if (awaited_readings.size() == 0)
            note_mismatch("unexpected result beat", 32'd0, 32'd1);
         else
            check_reading(awaited_readings.pop_front(), seen_reading);
         readings_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[byte_rate_ewma_meter_top] ERROR");
         $finish;
      end
   end

endmodule

[files.f]
hdl/bre_pkg.sv
hdl/bre_ifs.sv
hdl/bre_div.sv
hdl/bre_split.sv
hdl/byte_rate_ewma_meter_top.sv
hdl/bre_checker.sv
sim/tb_byte_rate_ewma_meter_top.sv
